/* hw/rtl/ted_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ted_pkg
// Types and constants shared by the text encoding decoder.
// ----------------------------------------------------------------------------
package ted_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned CntW  = 3;
  localparam int unsigned HsW   = 10;
  localparam int unsigned ModeW = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_ASCII = 2'd0,
    MODE_UCS2  = 2'd1,
    MODE_UTF8  = 2'd2,
    MODE_UTF16 = 2'd3
  } ted_mode_e;

  localparam ted_mode_e ModeReset = MODE_UTF8;

  localparam logic [CpW-1:0]  Replacement = 21'h00FFFD;
  localparam logic [CpW-1:0]  SuppBase    = 21'h010000;
  localparam logic [5:0]      HighSurr    = 6'b110110;

  localparam logic [CntW-1:0] Len1 = 3'd1;
  localparam logic [CntW-1:0] Len2 = 3'd2;
  localparam logic [CntW-1:0] Len3 = 3'd3;
  localparam logic [CntW-1:0] Len4 = 3'd4;

  typedef struct packed {
    logic [CpW-1:0]  partial;
    logic [CntW-1:0] seen;
    logic [CntW-1:0] expected;
    logic [HsW-1:0]  high_surr;
  } ted_state_t;

  typedef struct packed {
    logic            valid;
    logic [CpW-1:0]  code_point;
    logic [CntW-1:0] char_bytes;
  } ted_result_t;

endpackage

/* hw/rtl/ted_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ted_in_if / ted_out_if
// Request channels into and out of the text encoding decoder.
// ----------------------------------------------------------------------------
interface ted_in_if;
  logic                     valid;
  logic                     ready;
  logic [ted_pkg::ByteW-1:0] data_byte;
  logic                     string_start;

  modport source (output valid, output data_byte, output string_start, input ready);
  modport sink   (input valid, input data_byte, input string_start, output ready);
endinterface

interface ted_out_if;
  logic                     valid;
  logic                     ready;
  logic [ted_pkg::CpW-1:0]  code_point;
  logic [ted_pkg::CntW-1:0] char_bytes;

  modport source (output valid, output code_point, output char_bytes, input ready);
  modport sink   (input valid, input code_point, input char_bytes, output ready);
endinterface

/* hw/rtl/ted_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ted_step
// Next decoder state and optional code point for one encoded byte.
// ----------------------------------------------------------------------------
module ted_step (
  input  ted_pkg::ted_mode_e           mode_i,
  input  ted_pkg::ted_state_t          state_i,
  input  logic [ted_pkg::ByteW-1:0]    data_byte_i,
  input  logic                         string_start_i,
  output ted_pkg::ted_state_t          state_o,
  output ted_pkg::ted_result_t         result_o
);
  import ted_pkg::*;

  ted_state_t      cur;
  ted_state_t      nxt;
  ted_result_t     res;
  logic [CpW-1:0]  cont_val;
  logic [CntW-1:0] cont_seen;
  logic [15:0]     unit;

  always_comb begin
    cur       = string_start_i ? '0 : state_i;
    nxt       = cur;
    res       = '0;
    cont_val  = {cur.partial[CpW-7:0], data_byte_i[5:0]};
    cont_seen = cur.seen + Len1;
    unit      = {data_byte_i, cur.partial[7:0]};

    if (cur.seen == '0 || mode_i == MODE_ASCII) begin
      nxt = '0;
      unique case (mode_i)
        MODE_ASCII: begin
          res = '{valid: 1'b1, code_point: CpW'(data_byte_i), char_bytes: Len1};
        end
        MODE_UCS2, MODE_UTF16: begin
          nxt.partial  = CpW'(data_byte_i);
          nxt.seen     = Len1;
          nxt.expected = Len2;
        end
        MODE_UTF8: begin
          priority if (data_byte_i[7] == 1'b0) begin
            res = '{valid: 1'b1, code_point: CpW'(data_byte_i), char_bytes: Len1};
          end else if (data_byte_i[7:5] == 3'b110) begin
            nxt.partial  = CpW'(data_byte_i[4:0]);
            nxt.seen     = Len1;
            nxt.expected = Len2;
          end else if (data_byte_i[7:4] == 4'b1110) begin
            nxt.partial  = CpW'(data_byte_i[3:0]);
            nxt.seen     = Len1;
            nxt.expected = Len3;
          end else if (data_byte_i[7:3] == 5'b11110) begin
            nxt.partial  = CpW'(data_byte_i[2:0]);
            nxt.seen     = Len1;
            nxt.expected = Len4;
          end else begin
            res = '{valid: 1'b1, code_point: Replacement, char_bytes: Len1};
          end
        end
        default: nxt = '0;
      endcase
    end else begin
      unique case (mode_i)
        MODE_UCS2: begin
          nxt = '0;
          res = '{valid: 1'b1, code_point: CpW'(unit), char_bytes: Len2};
        end
        MODE_UTF8: begin
          if (cont_seen >= cur.expected) begin
            nxt = '0;
            res = '{valid: 1'b1, code_point: cont_val, char_bytes: cur.expected};
          end else begin
            nxt.partial = cont_val;
            nxt.seen    = cont_seen;
          end
        end
        MODE_UTF16: begin
          priority if (cur.seen == Len1) begin
            if (unit[15:10] == HighSurr) begin
              nxt.high_surr = unit[HsW-1:0];
              nxt.partial   = '0;
              nxt.seen      = Len2;
              nxt.expected  = Len4;
            end else begin
              nxt = '0;
              res = '{valid: 1'b1, code_point: CpW'(unit), char_bytes: Len2};
            end
          end else if (cur.seen == Len2) begin
            nxt.partial = CpW'(data_byte_i);
            nxt.seen    = Len3;
          end else begin
            nxt = '0;
            res = '{valid: 1'b1,
                    code_point: SuppBase + CpW'({cur.high_surr, unit[HsW-1:0]}),
                    char_bytes: Len4};
          end
        end
        default: nxt = '0;
      endcase
    end

    state_o  = nxt;
    result_o = res;
  end

endmodule

/* hw/rtl/text_encoding_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_encoding_decoder
// Streaming ASCII / UCS-2 LE / UTF-8 / UTF-16 LE byte decoder.
//
// in_i carries one encoded byte per request, with string_start to drop any
// partial character. out_o carries a code point and its byte count each
// time a character completes; bytes that only extend a character give no
// request on out_o. encoding_mode is written through cfg_we_i/cfg_wdata_i;
// the user must write it only while the block is idle, which the block
// itself does not enforce; a write also drops any partial character.
// Throughput: one byte per cycle while out_o is not stalled, set by the
// single decode step between the input register and the result register.
// Reset: decoder state clears, mode returns to UTF-8, both stages empty.
// Stall: while out_o is held and full, the input stage holds its byte and
// in_i.ready drops once that stage is also occupied; nothing is lost.
// ----------------------------------------------------------------------------
module text_encoding_decoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ted_pkg::ModeW-1:0] cfg_wdata_i,
  ted_in_if.sink                    in_i,
  ted_out_if.source                 out_o
);
  import ted_pkg::*;

  ted_mode_e        mode_q;
  ted_state_t       state_q;
  ted_state_t       state_d;
  ted_result_t      step_res;

  logic             s1_valid_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_start_q;

  logic             out_valid_q;
  logic [CpW-1:0]   out_cp_q;
  logic [CntW-1:0]  out_bytes_q;

  logic             out_free;
  logic             s1_adv;

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || s1_adv;

  ted_step u_step (
    .mode_i         (mode_q),
    .state_i        (state_q),
    .data_byte_i    (s1_byte_q),
    .string_start_i (s1_start_q),
    .state_o        (state_d),
    .result_o       (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeReset;
      state_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q  <= ted_mode_e'(cfg_wdata_i);
        state_q <= '0;
      end else if (s1_adv) begin
        state_q <= state_d;
      end
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_adv && step_res.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q  <= in_i.data_byte;
      s1_start_q <= in_i.string_start;
    end
    if (s1_adv && step_res.valid) begin
      out_cp_q    <= step_res.code_point;
      out_bytes_q <= step_res.char_bytes;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.code_point = out_cp_q;
  assign out_o.char_bytes = out_bytes_q;

  // held input byte survives an output stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_byte_q))
    else $error("input stage lost a byte during stall");

  // result byte count is always one to four
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_bytes_q == Len1 || out_bytes_q == Len2 ||
                     out_bytes_q == Len3 || out_bytes_q == Len4))
    else $error("bad char_bytes on result");

  // a pending character never has all its bytes already
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.seen != '0 |-> state_q.seen < state_q.expected)
    else $error("partial character overran its length");

  // ascii never leaves a partial character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_ASCII |-> state_q.seen == '0)
    else $error("partial character held in ascii mode");

  // a completing byte with room downstream always reaches the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && step_res.valid && !cfg_we_i |=> out_valid_q)
    else $error("completed character dropped");

endmodule
